[rtl/core/tuid_pkg.sv]
// ----------------------------------------------------------------------------
// tuid_pkg
// Shared types, constants and the digit alphabet of the time-ordered id block.
// ----------------------------------------------------------------------------
package tuid_pkg;

  localparam int unsigned TsW       = 63;
  localparam int unsigned TsEncW    = 48;
  localparam int unsigned RandLoW   = 60;
  localparam int unsigned RandHiW   = 12;
  localparam int unsigned CharW     = 7;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned IdLen     = 20;
  localparam int unsigned WordW     = TsEncW + RandHiW + RandLoW;
  localparam int unsigned ShiftW    = 7;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(IdLen - 1);

  // ascii codes of the alphabet anchors
  localparam logic [CharW-1:0] AsciiDash  = 7'd45;
  localparam logic [CharW-1:0] AsciiZero  = 7'd48;
  localparam logic [CharW-1:0] AsciiUpA   = 7'd65;
  localparam logic [CharW-1:0] AsciiUnder = 7'd95;
  localparam logic [CharW-1:0] AsciiLowA  = 7'd97;

  // digit codes at the group boundaries
  localparam logic [DigitW-1:0] DigDash   = 6'd0;
  localparam logic [DigitW-1:0] DigZero   = 6'd1;
  localparam logic [DigitW-1:0] DigUpA    = 6'd11;
  localparam logic [DigitW-1:0] DigUnder  = 6'd37;
  localparam logic [DigitW-1:0] DigLowA   = 6'd38;

  // one queued identifier: encoded time bits and the two counter parts
  typedef struct packed {
    logic [TsEncW-1:0]  ts_bits;
    logic [RandHiW-1:0] cnt_high;
    logic [RandLoW-1:0] cnt_low;
  } tuid_entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } tuid_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tuid_qsts_t;

  // map a six-bit digit onto its alphabet character
  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {1'b0, d};
    if (d == DigDash) begin
      return AsciiDash;
    end else if (d < DigUpA) begin
      return AsciiZero + (dx - {1'b0, DigZero});
    end else if (d < DigUnder) begin
      return AsciiUpA + (dx - {1'b0, DigUpA});
    end else if (d == DigUnder) begin
      return AsciiUnder;
    end else begin
      return AsciiLowA + (dx - {1'b0, DigLowA});
    end
  endfunction

endpackage

[rtl/core/tuid_if.sv]
// ----------------------------------------------------------------------------
// tuid_if
// Valid/ready channels: the request channel and the character channel.
// ----------------------------------------------------------------------------
interface tuid_req_if
  import tuid_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [TsW-1:0]     timestamp;
  logic [RandLoW-1:0] random_low;
  logic [RandHiW-1:0] random_high;

  modport source (output valid, output timestamp, output random_low,
                  output random_high, input ready);
  modport sink   (input valid, input timestamp, input random_low,
                  input random_high, output ready);
endinterface

interface tuid_chr_if
  import tuid_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] id_char;
  logic [IdxW-1:0]  char_index;
  logic             last_char;

  modport source (output valid, output id_char, output char_index,
                  output last_char, input ready);
  modport sink   (input valid, input id_char, input char_index,
                  input last_char, output ready);
endinterface

[rtl/core/tuid_front.sv]
// ----------------------------------------------------------------------------
// tuid_front
// Accepts requests, compares the timestamp and updates the time and counters.
// ----------------------------------------------------------------------------
module tuid_front
  import tuid_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  tuid_req_if.sink      req_i,
  input  tuid_qsts_t    qsts_i,
  output logic          push_o,
  output tuid_entry_t   entry_o
);

  logic [TsW-1:0]     prev_time_q, prev_time_d;
  logic [RandLoW-1:0] cnt_low_q, cnt_low_d;
  logic [RandHiW-1:0] cnt_high_q, cnt_high_d;
  logic               take;

  assign req_i.ready = !qsts_i.full;
  assign take        = req_i.valid && req_i.ready;

  // new timestamp reloads the counters, a repeat increments them
  always_comb begin
    prev_time_d = prev_time_q;
    cnt_low_d   = cnt_low_q;
    cnt_high_d  = cnt_high_q;
    if (take) begin
      if (req_i.timestamp != prev_time_q) begin
        prev_time_d = req_i.timestamp;
        cnt_low_d   = req_i.random_low;
        cnt_high_d  = req_i.random_high;
      end else begin
        cnt_low_d = cnt_low_q + RandLoW'(1);
        if (&cnt_low_q) begin
          cnt_high_d = cnt_high_q + RandHiW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      cnt_low_q   <= '0;
      cnt_high_q  <= '0;
    end else begin
      prev_time_q <= prev_time_d;
      cnt_low_q   <= cnt_low_d;
      cnt_high_q  <= cnt_high_d;
    end
  end

  // queue entry built from the updated state
  assign push_o           = take;
  assign entry_o.ts_bits  = prev_time_d[TsEncW-1:0];
  assign entry_o.cnt_high = cnt_high_d;
  assign entry_o.cnt_low  = cnt_low_d;

endmodule

[rtl/core/tuid_fifo.sv]
// ----------------------------------------------------------------------------
// tuid_fifo
// Two-entry queue of identifiers between front and back.
// ----------------------------------------------------------------------------
module tuid_fifo
  import tuid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tuid_qctl_t  qctl_i,
  input  tuid_entry_t entry_i,
  output tuid_qsts_t  qsts_o,
  output tuid_entry_t entry_o
);

  tuid_entry_t slot_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        do_push, do_pop;

  assign qsts_o.full  = (fill_q == 2'd2);
  assign qsts_o.empty = (fill_q == 2'd0);
  assign do_push      = qctl_i.push && !qsts_o.full;
  assign do_pop       = qctl_i.pop && !qsts_o.empty;
  assign entry_o      = slot_q[rptr_q];

  // pointer and fill update
  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    fill_d = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/tuid_back.sv]
// ----------------------------------------------------------------------------
// tuid_back
// Serializes the queue head into twenty characters through an output register.
// ----------------------------------------------------------------------------
module tuid_back
  import tuid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tuid_qsts_t  qsts_i,
  input  tuid_entry_t entry_i,
  output logic        pop_o,
  tuid_chr_if.source  chr_o
);

  logic [IdxW-1:0]   pos_q, pos_d;
  logic              oval_q, oval_d;
  logic [CharW-1:0]  ochar_q;
  logic [IdxW-1:0]   oidx_q;
  logic              olast_q;
  logic              advance;
  logic              at_last;
  logic [WordW-1:0]  word;
  logic [ShiftW-1:0] offset;
  logic [DigitW-1:0] digit;

  // pick the digit for the current position, most significant first
  assign word    = entry_i;
  assign offset  = ShiftW'(DigitW) * (ShiftW'(IdLen - 1) - ShiftW'(pos_q));
  assign digit   = word[offset +: DigitW];
  assign at_last = (pos_q == LastIdx);
  assign advance = !qsts_i.empty && (!oval_q || chr_o.ready);
  assign pop_o   = advance && at_last;

  always_comb begin
    pos_d  = pos_q;
    oval_d = oval_q;
    if (advance) begin
      pos_d  = at_last ? '0 : pos_q + IdxW'(1);
      oval_d = 1'b1;
    end else if (chr_o.ready) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      oval_q <= oval_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ochar_q <= digit_to_ascii(digit);
      oidx_q  <= pos_q;
      olast_q <= at_last;
    end
  end

  assign chr_o.valid      = oval_q;
  assign chr_o.id_char    = ochar_q;
  assign chr_o.char_index = oidx_q;
  assign chr_o.last_char  = olast_q;

endmodule

[rtl/core/time_ordered_unique_id_gen.sv]
// ----------------------------------------------------------------------------
// time_ordered_unique_id_gen
// Time-ordered unique identifier generator, twenty ascii characters a request.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  request channel: timestamp plus 72 random bits. The random bits are
//          used only when the timestamp differs from the last one seen;
//          otherwise the 72-bit counter increments.
//   chr_o  character channel: one id_char per transfer, char_index 0..19,
//          last_char set on the twentieth character.
// Timing: a taken request is first written into the queue; its first character
//   then appears through the output register. Throughput: one character per
//   cycle while the receiver is ready, set by the single-character output channel.
// A two-entry queue sits between the request front and the character back,
//   so up to two identifiers wait while the receiver stalls; req_i.ready drops
//   when the queue is full. A stalled character holds in the output register.
// Reset clears the stored time and counters to zero and empties the queue;
//   a first request with timestamp zero therefore counts as a repeat.
// ----------------------------------------------------------------------------
module time_ordered_unique_id_gen
  import tuid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tuid_req_if.sink   req_i,
  tuid_chr_if.source chr_o
);

  tuid_qctl_t  qctl;
  tuid_qsts_t  qsts;
  tuid_entry_t push_entry;
  tuid_entry_t head_entry;
  logic        q_push;
  logic        q_pop;

  // queue control gathered from front and back
  assign qctl = '{push: q_push, pop: q_pop};

  tuid_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .qsts_i  (qsts),
    .push_o  (q_push),
    .entry_o (push_entry)
  );

  tuid_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qctl_i  (qctl),
    .entry_i (push_entry),
    .qsts_o  (qsts),
    .entry_o (head_entry)
  );

  tuid_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qsts_i  (qsts),
    .entry_i (head_entry),
    .pop_o   (q_pop),
    .chr_o   (chr_o)
  );

endmodule
